### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: item and result
// payloads, item kinds, character codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;

  localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CH_W-1:0]   CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0]   CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0]   TEXT_ATTR    = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0720;
  localparam logic [CELL_W-1:0] BLANK_WRITE  = 16'h0F20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the incoming item
    logic exec;       // cell write/read and cursor update
    logic clr_step;   // one cell of the power-up clear
    logic scrl_step;  // one cell of the bottom-row blanking
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic scrl_last;
    logic need_scroll;
  } dp_status_t;

endpackage

### src/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: character put, cursor set and cell read on a
// LINES x COLUMNS screen of attribute/character cells.
// ----------------------------------------------------------------------------
// The start transfer latches the item, ST_EXEC executes it and ST_RESP gives the
// result strobe; busy stays high until then, so no new item is taken. A put that
// scrolls passes ST_SCROLL to blank the new bottom row (the screen is a circular
// row buffer, so no lines are copied). Reset: cursor goes home, then a clear sweep
// fills the screen with blanks while busy is high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item_i,
  output logic             done_o,
  output tcw_pkg::result_t result_o
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule

### src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: power-up clear sweep, item execution, bottom-row
// blanking on scroll, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_scroll ? ST_SCROLL : ST_RESP;
      end
      ST_SCROLL: begin
        cmd_o.scrl_step = 1'b1;
        if (status_i.scrl_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Console datapath: screen memory, cursor, top-row pointer of the circular
// screen, sweep counter and the result fields.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcw_pkg::dp_cmd_t    cmd_i,
  output tcw_pkg::dp_status_t status_o,
  input  tcw_pkg::item_t      item_i,
  output tcw_pkg::result_t    result_o
);

  localparam int unsigned CELLS = COLUMNS * LINES;
  localparam int unsigned AW    = $clog2(CELLS);

  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(LINES - 1);
  localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(COLUMNS - 1);

  logic [tcw_pkg::CELL_W-1:0] screen_q [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rd_q;

  tcw_pkg::item_t             item_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]  top_q;
  logic [AW-1:0]              cnt_q;
  logic [AW-1:0]              scrl_base_q;

  logic                       is_put, is_set, is_read, is_nl, is_bs;
  logic [tcw_pkg::ROW_W-1:0]  row_clamp, row_sel, prow;
  logic [tcw_pkg::COL_W-1:0]  col_clamp, col_sel;
  logic [tcw_pkg::ROW_W:0]    prow_sum;
  logic [AW-1:0]              exec_addr, mem_addr;
  logic                       mem_we, rd_en;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [AW-1:0]              pos_full;

  assign is_put  = (item_q.kind == tcw_pkg::KIND_PUT);
  assign is_set  = (item_q.kind == tcw_pkg::KIND_SET);
  assign is_read = (item_q.kind == tcw_pkg::KIND_READ);
  assign is_nl   = (item_q.ch == tcw_pkg::CH_NEWLINE);
  assign is_bs   = (item_q.ch == tcw_pkg::CH_BACKSPACE);

  assign row_clamp = (32'(item_q.row) >= LINES)   ? LAST_ROW : item_q.row;
  assign col_clamp = (32'(item_q.col) >= COLUMNS) ? LAST_COL : item_q.col;

  // logical row -> physical row of the circular screen
  always_comb begin
    row_sel  = is_read ? row_clamp : row_q;
    col_sel  = is_read ? col_clamp : (is_bs ? col_q - 1'b1 : col_q);
    prow_sum = {1'b0, row_sel} + {1'b0, top_q};
    if (32'(prow_sum) >= LINES) prow_sum = prow_sum - (tcw_pkg::ROW_W+1)'(LINES);
    prow      = prow_sum[tcw_pkg::ROW_W-1:0];
    exec_addr = AW'(AW'(prow) * AW'(COLUMNS)) + AW'(col_sel);
  end

  // cursor update of one item
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (is_put) begin
      if (is_bs) begin
        if (col_q != '0) col_d = col_q - 1'b1;
      end else if (is_nl || col_q == LAST_COL) begin
        col_d = '0;
        if (row_q != LAST_ROW) row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (is_set) begin
      row_d = row_clamp;
      col_d = col_clamp;
    end
  end

  assign status_o.need_scroll = is_put && !is_bs && (row_q == LAST_ROW) &&
                                (is_nl || col_q == LAST_COL);
  assign status_o.clr_last    = (cnt_q == AW'(CELLS - 1));
  assign status_o.scrl_last   = (cnt_q == AW'(COLUMNS - 1));

  // single memory port
  always_comb begin
    mem_addr  = exec_addr;
    mem_wdata = {tcw_pkg::TEXT_ATTR, item_q.ch};
    mem_we    = 1'b0;
    if (cmd_i.clr_step) begin
      mem_addr  = cnt_q;
      mem_wdata = tcw_pkg::BLANK_RESET;
      mem_we    = 1'b1;
    end else if (cmd_i.scrl_step) begin
      mem_addr  = scrl_base_q + cnt_q;
      mem_wdata = tcw_pkg::BLANK_WRITE;
      mem_we    = 1'b1;
    end else if (cmd_i.exec && is_put && !is_nl) begin
      if (is_bs) begin
        mem_wdata = tcw_pkg::BLANK_WRITE;
        mem_we    = (col_q != '0);
      end else begin
        mem_we    = 1'b1;
      end
    end
  end

  assign rd_en = cmd_i.exec && is_read;

  always_ff @(posedge clk_i) begin
    if (mem_we) screen_q[mem_addr] <= mem_wdata;
    if (rd_en)  rd_q <= screen_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= item_i;
    // the old top physical row becomes the blank bottom row
    if (cmd_i.exec)  scrl_base_q <= AW'(AW'(top_q) * AW'(COLUMNS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      top_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        row_q <= row_d;
        col_q <= col_d;
        if (status_o.need_scroll) cnt_q <= '0;
      end
      if (cmd_i.clr_step) begin
        cnt_q <= status_o.clr_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.scrl_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (status_o.scrl_last) top_q <= (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
      end
    end
  end

  assign pos_full = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);

  always_comb begin
    result_o.cursor_row = row_q;
    result_o.cursor_col = col_q;
    result_o.cursor_pos = tcw_pkg::POS_W'({{tcw_pkg::POS_W{1'b0}}, pos_full});
    result_o.cell_value = is_read ? rd_q : '0;
  end

endmodule
